FILE: design/stlc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the smoothed thermistor lookup core.
// Used by every module of the block; depends on nothing else.
package stlc_pkg;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_TABLE_DEPTH   = 64;
  localparam int DEFAULT_FILTER_WEIGHT = 30;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_START_TEMP = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES    = 1'd1;
  localparam logic [7:0] START_TEMP_RESET = 8'd0;
  localparam logic [6:0] ENTRIES_RESET    = 7'd64;

  // Item kinds.
  localparam logic OP_SAMPLE      = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] sample;
    logic [5:0] entry_index;
    logic [7:0] entry_value;
  } item_t;

  typedef struct packed {
    logic signed [7:0] temp_half_deg;
    logic [7:0]        smoothed_level;
  } result_t;

  // Classified command as held in the queue.
  typedef struct packed {
    logic       op;
    logic [5:0] index;
    logic [7:0] data;
  } cmd_t;

endpackage

FILE: design/stlc_front.sv
`timescale 1ns / 1ps
// Front part: accepts input items, drops table writes that fall outside the
// table and packs the rest into queue commands. Depends on stlc_pkg.
module stlc_front import stlc_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic  push,
  input  item_t item,
  output logic  full,
  input  logic  queue_full,
  output logic  enq,
  output cmd_t  enq_cmd
);

  localparam int IDX_CMP_W = 9;

  logic accepted;
  logic keep;

  assign full     = queue_full;
  assign accepted = push && !queue_full;

  // A write beyond the table is accepted but has no effect.
  assign keep = (item.cmd == OP_SAMPLE) ||
                (IDX_CMP_W'(item.entry_index) < IDX_CMP_W'(TABLE_DEPTH));

  assign enq = accepted && keep;

  always_comb begin
    enq_cmd.op    = item.cmd;
    enq_cmd.index = item.entry_index;
    enq_cmd.data  = (item.cmd == OP_SAMPLE) ? item.sample : item.entry_value;
  end

endmodule

FILE: design/stlc_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front and back parts.
// Depends on stlc_pkg for the command type and depth.
module stlc_queue import stlc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic enq,
  input  cmd_t enq_cmd,
  output logic full,
  output logic valid,
  output cmd_t head,
  input  logic deq
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_enq;
  logic             do_deq;

  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign valid  = (count != '0);
  assign head   = slots[rd_ptr];
  assign do_enq = enq && !full;
  assign do_deq = deq && valid;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slots[wr_ptr] <= enq_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_enq && !do_deq) begin
        count <= count + 1'b1;
      end else if (do_deq && !do_enq) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("command queue holds more than its depth");

  a_count_track : assert property (@(posedge clk) disable iff (rst)
    (do_enq && !do_deq) |=> count == $past(count) + 1'b1)
    else $error("command queue count missed a push");

endmodule

FILE: design/stlc_back.sv
`timescale 1ns / 1ps
// Back part: configuration registers, moving-average filter with a reciprocal
// divider, threshold table memory and table search. Depends on stlc_pkg.
module stlc_back import stlc_pkg::*; #(
  parameter int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int FILTER_WEIGHT = DEFAULT_FILTER_WEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_valid,
  input  cmd_t                   q_head,
  output logic                   q_deq,
  output logic                   empty,
  output result_t                result,
  input  logic                   pop
);

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W0  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W   = (CNT_W0 > 8) ? CNT_W0 : 8;
  localparam int ACC_W   = $clog2(256 * FILTER_WEIGHT);
  localparam int ACC_MAX = 256 * FILTER_WEIGHT - 1;
  localparam logic [ACC_W-1:0] DIVISOR = ACC_W'(FILTER_WEIGHT);

  // Rounded-up reciprocal of the weight; exact for every accumulator value.
  localparam int RECIP_SHIFT = ACC_W + $clog2(FILTER_WEIGHT);
  localparam int RECIP_W     = ACC_W + 1;
  localparam int PROD_W      = ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + FILTER_WEIGHT - 1) / FILTER_WEIGHT);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FILTER = 2'd1;
  localparam logic [1:0] ST_DIVIDE = 2'd2;
  localparam logic [1:0] ST_SEARCH = 2'd3;

  logic [7:0] table_mem [TABLE_DEPTH];
  logic [7:0] rd_data;

  logic [1:0]        state;
  logic [7:0]        start_temp;
  logic [6:0]        entries_in_use;
  logic              seeded;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [PROD_W-1:0] product;
  logic [ACC_W-1:0]  level_rem;
  logic [7:0]        level;
  logic [7:0]        sample;
  logic [CMP_W-1:0]  count;
  logic [CMP_W-1:0]  count_sat;
  logic [CMP_W-1:0]  ptr;
  logic [CMP_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic              issue;
  logic              hit;
  logic              miss;
  logic [7:0]        offset;
  logic              mem_we;
  logic              res_valid;
  result_t           res;

  assign empty  = !res_valid;
  assign result = res;

  assign mem_we = (state == ST_IDLE) && q_valid && (q_head.op == OP_TABLE_WRITE);
  assign q_deq  = (state == ST_IDLE) && q_valid &&
                  ((q_head.op == OP_TABLE_WRITE) || !res_valid);

  assign count_sat = (CMP_W'(entries_in_use) > CMP_W'(TABLE_DEPTH)) ?
                     CMP_W'(TABLE_DEPTH) : CMP_W'(entries_in_use);

  // The previous level is already acc / N, so the update needs no divide.
  assign acc_next  = acc - ACC_W'(level) + ACC_W'(sample);
  assign product   = PROD_W'(acc) * PROD_W'(RECIP);
  assign level_rem = acc - ACC_W'(level) * DIVISOR;

  // Reads are issued one entry per cycle; the compare runs in the cycle after each read.
  assign issue  = (state == ST_SEARCH) && (ptr < count);
  assign hit    = (state == ST_SEARCH) && cmp_valid && (level >= rd_data);
  assign miss   = (state == ST_SEARCH) && !cmp_valid && !issue;
  assign offset = hit ? 8'(cmp_idx - CMP_W'(1)) : 8'(count - CMP_W'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[AW'(q_head.index)] <= q_head.data;
    end
    rd_data <= table_mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      start_temp     <= START_TEMP_RESET;
      entries_in_use <= ENTRIES_RESET;
      seeded         <= 1'b0;
      cmp_valid      <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_START_TEMP: start_temp <= cfg_data[7:0];
          REG_ENTRIES:    entries_in_use <= cfg_data[6:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (q_deq && (q_head.op == OP_SAMPLE)) begin
            sample    <= q_head.data;
            count     <= count_sat;
            ptr       <= CMP_W'(1);
            cmp_valid <= 1'b0;
            state     <= ST_FILTER;
          end
        end
        ST_FILTER: begin
          if (!seeded) begin
            acc    <= ACC_W'(ACC_W'(sample) * DIVISOR);
            level  <= sample;
            seeded <= 1'b1;
            state  <= ST_SEARCH;
          end else begin
            acc   <= acc_next;
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          // Division by the weight as a multiply by its reciprocal and a shift.
          level <= product[RECIP_SHIFT +: 8];
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          cmp_valid <= issue;
          cmp_idx   <= ptr;
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          if (hit || miss) begin
            res.temp_half_deg  <= start_temp + offset;
            res.smoothed_level <= level;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (state == ST_SEARCH && (hit || miss)) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_result_from_search : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_SEARCH)
    else $error("result appeared without a finished search");

  a_divide_remainder : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> level_rem < DIVISOR)
    else $error("filter level is not the accumulator divided by the weight");

  a_acc_bound : assert property (@(posedge clk) disable iff (rst)
    seeded |-> acc <= ACC_W'(ACC_MAX))
    else $error("filter accumulator out of range");

  a_no_sample_while_full : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILTER) |-> !res_valid || $past(pop))
    else $error("sample started while a result was still waiting");

endmodule

FILE: design/smoothed_thermistor_temperature_lookup_core.sv
`timescale 1ns / 1ps
// Top level of the smoothed thermistor lookup core: ties the front part,
// the command queue and the back part together. Depends on stlc_pkg.
//
// Items enter through a two-entry command queue, so the input keeps accepting
// while the back part works and while a result waits to be popped, until the
// queue is full. A table write is written to the table memory as it leaves the
// queue in the back part's idle state. A sample leaves the queue, then passes
// the filter step and a step that divides the accumulator by the weight with
// a reciprocal multiply (skipped for the first sample, which seeds the filter)
// and then the table search, which reads one entry per cycle from the table
// memory. A new sample starts only once the previous result has been popped.
// There is no clearing pass: table entries must be written before a search
// reaches them.
module smoothed_thermistor_temperature_lookup_core import stlc_pkg::*; #(
  parameter int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int FILTER_WEIGHT = DEFAULT_FILTER_WEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  item_t                  item,
  output logic                   full,
  output logic                   empty,
  output result_t                result,
  input  logic                   pop,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic queue_full;
  logic enq;
  cmd_t enq_cmd;
  logic q_valid;
  cmd_t q_head;
  logic q_deq;

  stlc_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .push       (push),
    .item       (item),
    .full       (full),
    .queue_full (queue_full),
    .enq        (enq),
    .enq_cmd    (enq_cmd)
  );

  stlc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_cmd (enq_cmd),
    .full    (queue_full),
    .valid   (q_valid),
    .head    (q_head),
    .deq     (q_deq)
  );

  stlc_back #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .FILTER_WEIGHT(FILTER_WEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_deq     (q_deq),
    .empty     (empty),
    .result    (result),
    .pop       (pop)
  );

endmodule
